>>> rtl/image_rotate_nearest_macros.svh
// Assertion macros shared by the image rotation RTL.
`ifndef IMAGE_ROTATE_NEAREST_MACROS_SVH
`define IMAGE_ROTATE_NEAREST_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define IRN_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that a condition never holds at a rising clock edge outside reset.
`define IRN_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define IRN_ASSERT(lbl, clk, rst_n, prop)
`define IRN_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> rtl/irn_pkg.sv
// Types and constants shared by the image rotation RTL.
`timescale 1ns / 1ps

package irn_pkg;

    localparam int DIM_W  = 9;
    localparam int POS_W  = 8;
    localparam int PIX_W  = 8;
    localparam int ANG_W  = 16;
    localparam int CRD_W  = DIM_W + 2;
    localparam int PROD_W = ANG_W + CRD_W;

    localparam int CMDQ_DEPTH = 16;
    localparam int OUTQ_DEPTH = 4;

    localparam int APB_DW    = 32;
    localparam int PADDR_W   = 4;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COS    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SIN    = 2'd3;

    localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd256;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 9'd256;
    localparam logic [ANG_W-1:0] COS_RESET    = 16'd16384;
    localparam logic [ANG_W-1:0] SIN_RESET    = 16'd0;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] pixel_in;
    } req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             inside_res;
    } rsp_t;

    typedef struct packed {
        logic        [DIM_W-1:0] image_height;
        logic        [DIM_W-1:0] image_width;
        logic signed [ANG_W-1:0] cos_angle;
        logic signed [ANG_W-1:0] sin_angle;
    } cfg_t;

    // Control bits of one request handed from front to back.
    typedef struct packed {
        logic is_read;
        logic wen;
        logic in_img;
    } cmd_ctl_t;

endpackage

>>> rtl/image_rotate_nearest.sv
// Top level of the nearest-neighbor image rotator with its frame store.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+------------------------------------
//  request   | push / full                   | req: kind, row, col, pixel_in
//  result    | pop / empty                   | rsp: pixel_out, inside_res
//  config    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Sustained rate is one request per cycle while full stays low, writes and reads mixed in any order.
// A read result reaches the ports through six mapping stages (the first loaded at
// the accepting edge), the command queue, the registered store read, and the result
// queue.
// full rises once 16 requests sit between acceptance and the back part, which only
// happens while the back part stalls on an undrained 4-entry result queue; it falls
// as soon as the back part takes a request again.
// Reset clears control state and loads the register defaults; the frame store
// itself is not cleared and holds garbage until written.
`timescale 1ns / 1ps

module image_rotate_nearest #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_COLS  = 256,
    parameter int FRAC_BITS = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  irn_pkg::req_t                 req,
    input  logic                          pop,
    output logic                          empty,
    output irn_pkg::rsp_t                 rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [irn_pkg::PADDR_W-1:0]   paddr,
    input  logic [irn_pkg::APB_DW-1:0]    pwdata,
    output logic [irn_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CU_W    = $clog2(irn_pkg::CMDQ_DEPTH + 1);
    localparam int CMD_W   = $bits(irn_pkg::cmd_ctl_t) + ADDR_W + irn_pkg::PIX_W;

    // Configuration registers.
    logic [irn_pkg::DIM_W-1:0]   height_reg;
    logic [irn_pkg::DIM_W-1:0]   width_reg;
    logic [irn_pkg::ANG_W-1:0]   cos_reg;
    logic [irn_pkg::ANG_W-1:0]   sin_reg;
    irn_pkg::cfg_t               cfg;
    logic                        cfg_wr;
    logic [irn_pkg::REG_IDX_W-1:0] reg_idx;

    // Request flow from front to back.
    logic                        take;
    logic                        f_valid;
    irn_pkg::cmd_ctl_t           f_ctl;
    logic [ADDR_W-1:0]           f_addr;
    logic [irn_pkg::PIX_W-1:0]   f_wdata;
    logic [CMD_W-1:0]            q_data;
    logic                        cmdq_empty;
    logic                        cmdq_full;
    logic                        cmd_pop;
    irn_pkg::cmd_ctl_t           b_ctl;
    logic [ADDR_W-1:0]           b_addr;
    logic [irn_pkg::PIX_W-1:0]   b_wdata;

    // Requests accepted but not yet taken by the back part.
    logic [CU_W-1:0]             cmd_used_reg;
    logic [CU_W-1:0]             cmd_used_next;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[irn_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= irn_pkg::HEIGHT_RESET;
            width_reg  <= irn_pkg::WIDTH_RESET;
            cos_reg    <= irn_pkg::COS_RESET;
            sin_reg    <= irn_pkg::SIN_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                irn_pkg::REG_HEIGHT: height_reg <= pwdata[irn_pkg::DIM_W-1:0];
                irn_pkg::REG_WIDTH:  width_reg  <= pwdata[irn_pkg::DIM_W-1:0];
                irn_pkg::REG_COS:    cos_reg    <= pwdata[irn_pkg::ANG_W-1:0];
                irn_pkg::REG_SIN:    sin_reg    <= pwdata[irn_pkg::ANG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the raw register contents, zero-extended.
    always_comb
    begin
        case (reg_idx)
            irn_pkg::REG_HEIGHT: prdata = irn_pkg::APB_DW'(height_reg);
            irn_pkg::REG_WIDTH:  prdata = irn_pkg::APB_DW'(width_reg);
            irn_pkg::REG_COS:    prdata = irn_pkg::APB_DW'(cos_reg);
            irn_pkg::REG_SIN:    prdata = irn_pkg::APB_DW'(sin_reg);
            default:             prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.image_height = height_reg;
        cfg.image_width  = width_reg;
        cfg.cos_angle    = $signed(cos_reg);
        cfg.sin_angle    = $signed(sin_reg);
    end

    // Credit count: the front pipeline never stalls, so admit a request only
    // while the command queue can still absorb everything in flight.
    assign full          = (cmd_used_reg == CU_W'(irn_pkg::CMDQ_DEPTH));
    assign take          = push && !full;
    assign cmd_used_next = cmd_used_reg + CU_W'(take) - CU_W'(cmd_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_used_reg <= '0;
        end
        else
        begin
            cmd_used_reg <= cmd_used_next;
        end
    end

    // Front: classify and map coordinates in a fixed six-stage pipeline.
    irn_front #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .FRAC_BITS (FRAC_BITS),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .req       (req),
        .cfg       (cfg),
        .cmd_valid (f_valid),
        .cmd_ctl   (f_ctl),
        .cmd_addr  (f_addr),
        .cmd_wdata (f_wdata)
    );

    // Decouple the front from store access and result backpressure.
    irn_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (irn_pkg::CMDQ_DEPTH)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_valid),
        .wdata ({f_ctl, f_addr, f_wdata}),
        .pop   (cmd_pop),
        .rdata (q_data),
        .empty (cmdq_empty),
        .full  (cmdq_full)
    );

    assign {b_ctl, b_addr, b_wdata} = q_data;

    // Back: one store access per cycle unless a read waits for a result slot; results go through a short queue.
    irn_back #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmdq_empty),
        .cmd_ctl   (b_ctl),
        .cmd_addr  (b_addr),
        .cmd_wdata (b_wdata),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .rsp       (rsp)
    );

`include "image_rotate_nearest_macros.svh"

    `IRN_ASSERT_NEVER(a_cmdq_overflow, clk, rst_n, f_valid && cmdq_full)
    `IRN_ASSERT(a_credit_step, clk, rst_n, (take && !cmd_pop) |=> (cmd_used_reg == CU_W'($past(cmd_used_reg) + 1'b1)))

endmodule

>>> rtl/irn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module irn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/irn_fifo.sv
// Small register queue with the oldest entry shown at the read side.
`timescale 1ns / 1ps

module irn_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic             full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/irn_front.sv
// Front part: classify requests and map output pixels back to source cells.
`timescale 1ns / 1ps

module irn_front #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_COLS  = 256,
    parameter int FRAC_BITS = 14,
    parameter int ADDR_W    = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  irn_pkg::req_t                  req,
    input  irn_pkg::cfg_t                  cfg,
    output logic                           cmd_valid,
    output irn_pkg::cmd_ctl_t              cmd_ctl,
    output logic [ADDR_W-1:0]              cmd_addr,
    output logic [irn_pkg::PIX_W-1:0]      cmd_wdata
);

    localparam int STAGES = 6;
    localparam int DIM_W  = irn_pkg::DIM_W;
    localparam int CRD_W  = irn_pkg::CRD_W;
    localparam int PROD_W = irn_pkg::PROD_W;
    localparam int ROW_IW = $clog2(MAX_ROWS);
    localparam int COL_IW = $clog2(MAX_COLS);
    localparam int SUM_W  = PROD_W + 1;
    localparam int OFF_W  = DIM_W + FRAC_BITS + 1;
    localparam int ACC_W  = ((SUM_W > OFF_W) ? SUM_W : OFF_W) + 1;
    localparam int MAG_W  = ACC_W - FRAC_BITS;
    localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << FRAC_BITS;

    logic [DIM_W-1:0] h_clamp;
    logic [DIM_W-1:0] w_clamp;
    logic [DIM_W-1:0] h_m1;
    logic [DIM_W-1:0] w_m1;

    logic [STAGES-1:0]               v_reg;
    irn_pkg::cmd_ctl_t               tag_reg  [STAGES];
    logic [ADDR_W-1:0]               addr_reg [STAGES];
    logic [irn_pkg::PIX_W-1:0]       data_reg [STAGES];

    irn_pkg::cmd_ctl_t               tag_next;
    logic [ADDR_W-1:0]               addr_next;
    logic signed [CRD_W-1:0]         x2_next;
    logic signed [CRD_W-1:0]         y2_next;
    logic signed [CRD_W-1:0]         x2_reg;
    logic signed [CRD_W-1:0]         y2_reg;
    logic signed [PROD_W-1:0]        pcx_reg;
    logic signed [PROD_W-1:0]        psy_reg;
    logic signed [PROD_W-1:0]        psx_reg;
    logic signed [PROD_W-1:0]        pcy_reg;
    logic signed [ACC_W-1:0]         off_w;
    logic signed [ACC_W-1:0]         off_h;
    logic signed [ACC_W-1:0]         qx_reg;
    logic signed [ACC_W-1:0]         qy_reg;
    logic                            negx4_reg;
    logic                            negy4_reg;
    logic [ACC_W-1:0]                absx_reg;
    logic [ACC_W-1:0]                absy_reg;
    logic                            negx5_reg;
    logic                            negy5_reg;
    logic [ACC_W:0]                  rndx;
    logic [ACC_W:0]                  rndy;
    logic [MAG_W-1:0]                magx_reg;
    logic [MAG_W-1:0]                magy_reg;
    logic                            src_ok;
    logic [ADDR_W-1:0]               src_addr;
    irn_pkg::cmd_ctl_t               tag6_next;

    // Dimensions in use: zero acts as one, oversize saturates to the store.
    always_comb
    begin
        if (cfg.image_height == '0)
        begin
            h_clamp = DIM_W'(1);
        end
        else if (int'(cfg.image_height) > MAX_ROWS)
        begin
            h_clamp = DIM_W'(MAX_ROWS);
        end
        else
        begin
            h_clamp = cfg.image_height;
        end
        if (cfg.image_width == '0)
        begin
            w_clamp = DIM_W'(1);
        end
        else if (int'(cfg.image_width) > MAX_COLS)
        begin
            w_clamp = DIM_W'(MAX_COLS);
        end
        else
        begin
            w_clamp = cfg.image_width;
        end
        h_m1 = h_clamp - 1'b1;
        w_m1 = w_clamp - 1'b1;
    end

    // Stage 1: classify, form the write address and the doubled centered point.
    always_comb
    begin
        tag_next.is_read = (req.kind == irn_pkg::KIND_READ);
        tag_next.wen     = (req.kind == irn_pkg::KIND_WRITE)
                           && (int'(req.row) < MAX_ROWS) && (int'(req.col) < MAX_COLS);
        tag_next.in_img  = (DIM_W'(req.row) < h_clamp) && (DIM_W'(req.col) < w_clamp);
        addr_next        = ADDR_W'(ROW_IW'(req.row)) * ADDR_W'(MAX_COLS)
                           + ADDR_W'(COL_IW'(req.col));
        x2_next          = $signed({2'b00, req.col, 1'b0}) - $signed({2'b00, w_m1});
        y2_next          = $signed({2'b00, req.row, 1'b0}) - $signed({2'b00, h_m1});
    end

    // Center offsets (W-1) and (H-1) scaled to the fraction.
    assign off_w = $signed({{(ACC_W - DIM_W - FRAC_BITS){1'b0}}, w_m1, {FRAC_BITS{1'b0}}});
    assign off_h = $signed({{(ACC_W - DIM_W - FRAC_BITS){1'b0}}, h_m1, {FRAC_BITS{1'b0}}});

    // Stage 5 rounding: magnitude plus half, then drop the fraction and the doubling.
    assign rndx = {1'b0, absx_reg} + HALF;
    assign rndy = {1'b0, absy_reg} + HALF;

    // Stage 6: bounds check on the rounded source cell and its store address.
    always_comb
    begin
        src_ok = tag_reg[STAGES-2].in_img
                 && (!negx5_reg || magx_reg == '0) && (magx_reg < MAG_W'(w_clamp))
                 && (!negy5_reg || magy_reg == '0) && (magy_reg < MAG_W'(h_clamp));
        src_addr = ADDR_W'(ROW_IW'(magy_reg)) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(COL_IW'(magx_reg));
        tag6_next        = tag_reg[STAGES-2];
        tag6_next.in_img = src_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[STAGES-2:0], take};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0]  <= tag_next;
        addr_reg[0] <= addr_next;
        data_reg[0] <= req.pixel_in;
        for (int i = 1; i < STAGES - 1; i++)
        begin
            tag_reg[i]  <= tag_reg[i-1];
            addr_reg[i] <= addr_reg[i-1];
            data_reg[i] <= data_reg[i-1];
        end
        tag_reg[STAGES-1]  <= tag6_next;
        addr_reg[STAGES-1] <= tag_reg[STAGES-2].is_read ? src_addr : addr_reg[STAGES-2];
        data_reg[STAGES-1] <= data_reg[STAGES-2];

        x2_reg <= x2_next;
        y2_reg <= y2_next;

        pcx_reg <= PROD_W'(cfg.cos_angle) * PROD_W'(x2_reg);
        psy_reg <= PROD_W'(cfg.sin_angle) * PROD_W'(y2_reg);
        psx_reg <= PROD_W'(cfg.sin_angle) * PROD_W'(x2_reg);
        pcy_reg <= PROD_W'(cfg.cos_angle) * PROD_W'(y2_reg);

        qx_reg <= ACC_W'(pcx_reg) + ACC_W'(psy_reg) + off_w;
        qy_reg <= ACC_W'(pcy_reg) - ACC_W'(psx_reg) + off_h;

        negx4_reg <= qx_reg[ACC_W-1];
        negy4_reg <= qy_reg[ACC_W-1];
        absx_reg  <= qx_reg[ACC_W-1] ? ACC_W'(-qx_reg) : ACC_W'(qx_reg);
        absy_reg  <= qy_reg[ACC_W-1] ? ACC_W'(-qy_reg) : ACC_W'(qy_reg);

        negx5_reg <= negx4_reg;
        negy5_reg <= negy4_reg;
        magx_reg  <= rndx[ACC_W:FRAC_BITS+1];
        magy_reg  <= rndy[ACC_W:FRAC_BITS+1];
    end

    assign cmd_valid = v_reg[STAGES-1];
    assign cmd_ctl   = tag_reg[STAGES-1];
    assign cmd_addr  = addr_reg[STAGES-1];
    assign cmd_wdata = data_reg[STAGES-1];

`include "image_rotate_nearest_macros.svh"

    `IRN_ASSERT(a_front_latency, clk, rst_n, take |-> ##6 cmd_valid)

endmodule

>>> rtl/irn_back.sv
// Back part: carry out writes and reads on the frame store, queue the results.
`timescale 1ns / 1ps

module irn_back #(
    parameter int ADDR_W = 16,
    parameter int DEPTH  = 65536
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    input  irn_pkg::cmd_ctl_t         cmd_ctl,
    input  logic [ADDR_W-1:0]         cmd_addr,
    input  logic [irn_pkg::PIX_W-1:0] cmd_wdata,
    output logic                      cmd_pop,
    input  logic                      pop,
    output logic                      empty,
    output irn_pkg::rsp_t             rsp
);

    localparam int OU_W = $clog2(irn_pkg::OUTQ_DEPTH + 1);

    logic                      issue;
    logic                      issue_read;
    logic [OU_W-1:0]           out_used_reg;
    logic [OU_W-1:0]           out_used_next;
    logic                      res_v_reg;
    logic                      res_in_reg;
    logic [irn_pkg::PIX_W-1:0] rdata;
    irn_pkg::rsp_t             res;
    logic                      outq_full;

    // Hold a read until the result queue has a slot reserved for it.
    assign issue      = cmd_valid
                        && (!cmd_ctl.is_read
                            || out_used_reg < OU_W'(irn_pkg::OUTQ_DEPTH));
    assign issue_read = issue && cmd_ctl.is_read;
    assign cmd_pop    = issue;

    irn_ram #(
        .WIDTH (irn_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (issue && cmd_ctl.wen),
        .waddr (cmd_addr),
        .wdata (cmd_wdata),
        .raddr (cmd_addr),
        .rdata (rdata)
    );

    assign out_used_next = out_used_reg + OU_W'(issue_read) - OU_W'(pop && !empty);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_used_reg <= '0;
            res_v_reg    <= 1'b0;
        end
        else
        begin
            out_used_reg <= out_used_next;
            res_v_reg    <= issue_read;
        end
    end

    always_ff @(posedge clk)
    begin
        res_in_reg <= cmd_ctl.in_img;
    end

    always_comb
    begin
        res.pixel_out  = res_in_reg ? rdata : '0;
        res.inside_res = res_in_reg;
    end

    irn_fifo #(
        .WIDTH ($bits(irn_pkg::rsp_t)),
        .DEPTH (irn_pkg::OUTQ_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_v_reg),
        .wdata (res),
        .pop   (pop),
        .rdata (rsp),
        .empty (empty),
        .full  (outq_full)
    );

`include "image_rotate_nearest_macros.svh"

    `IRN_ASSERT_NEVER(a_outq_overflow, clk, rst_n, res_v_reg && outq_full)
    `IRN_ASSERT(a_write_no_result, clk, rst_n, (issue && !cmd_ctl.is_read) |=> !res_v_reg)

endmodule
